// File: rtl/sqtg_pkg.sv
// Package with the shared types and constants of the square tone generator.
package sqtg_pkg;

  // Command codes carried in the command field of an input word.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // Half-period count codes.
  localparam logic [31:0] ENDLESS_COUNT = 32'hffff_fffe;
  localparam logic [31:0] COUNT_MAX     = 32'hffff_fffd;

  // Reset value of the timer clock register.
  localparam logic [31:0] CLOCK_HZ_RESET = 32'd80_000_000;

  // Milliseconds per second, the divisor of the count computation.
  localparam int unsigned MS_PER_S = 1000;

  // Shared divider widths: the widest dividend is frequency * duration * 2
  // (20 + 32 + 1 bits); the widest divisor is frequency * 2 (21 bits).
  localparam int unsigned DIVIDEND_W = 53;
  localparam int unsigned DIVISOR_W  = 21;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // Width of the prescale shift.
  localparam int unsigned SHIFT_W = 5;

  // Input word.
  typedef struct packed {
    logic [1:0]  command;
    logic [19:0] frequency_hz;
    logic [31:0] duration_ms;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic pin_level;
    logic active;
  } out_word_t;

  // Operations issued to the tone timer.
  typedef struct packed {
    logic tick;
    logic load;
    logic stop;
  } timer_ctl_t;

endpackage

// File: rtl/sqtg_div.sv
// Shared restoring divider, one quotient bit per cycle.
module sqtg_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 go,
  input  logic [sqtg_pkg::DIVIDEND_W-1:0]      dividend,
  input  logic [sqtg_pkg::DIVISOR_W-1:0]       divisor,
  output logic                                 done,
  output logic [sqtg_pkg::DIVIDEND_W-1:0]      quotient
);

  logic                               busy;
  logic [sqtg_pkg::DIV_CNT_W-1:0]     steps;
  logic [sqtg_pkg::DIVISOR_W-1:0]     rem;
  logic [sqtg_pkg::DIVISOR_W-1:0]     dvsr;
  logic [sqtg_pkg::DIVIDEND_W-1:0]    quot;
  logic [sqtg_pkg::DIVISOR_W:0]       trial;
  logic [sqtg_pkg::DIVISOR_W:0]       diff;
  logic                               fits;

  // Shift the next dividend bit into the remainder and try the subtract.
  always_comb begin
    trial = {rem, quot[sqtg_pkg::DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvsr};
    fits  = (trial >= {1'b0, dvsr});
  end

  // Step control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy  <= 1'b1;
        steps <= sqtg_pkg::DIV_CNT_W'(sqtg_pkg::DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == sqtg_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quot <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[sqtg_pkg::DIVISOR_W-1:0];
      end else begin
        rem <= trial[sqtg_pkg::DIVISOR_W-1:0];
      end
      quot <= {quot[sqtg_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quot;

endmodule

// File: rtl/sqtg_timer.sv
// Tone timer: prescaler, reload counter, half-period count and output level.
module sqtg_timer #(
  parameter int unsigned RELOAD_W = 17
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sqtg_pkg::timer_ctl_t          ctl,
  input  logic [RELOAD_W-1:0]           load_reload,
  input  logic [sqtg_pkg::SHIFT_W-1:0]  load_shift,
  input  logic [31:0]                   load_count,
  output sqtg_pkg::out_word_t           state_next
);

  logic                          level;
  logic                          running;
  logic [31:0]                   half_periods_left;
  logic [RELOAD_W-1:0]           reload_value;
  logic [sqtg_pkg::SHIFT_W-1:0]  prescale_shift;
  logic [31:0]                   prescale_counter;
  logic [RELOAD_W-1:0]           period_counter;

  logic                          level_next;
  logic                          running_next;
  logic [31:0]                   half_periods_left_next;
  logic [RELOAD_W-1:0]           reload_value_next;
  logic [sqtg_pkg::SHIFT_W-1:0]  prescale_shift_next;
  logic [31:0]                   prescale_counter_next;
  logic [RELOAD_W-1:0]           period_counter_next;

  logic [32:0]                   pre_inc;
  logic                          pre_wrap;
  logic [RELOAD_W-1:0]           per_inc;

  // Counter increments and wrap tests.
  always_comb begin
    pre_inc  = {1'b0, prescale_counter} + 33'd1;
    pre_wrap = ((pre_inc >> prescale_shift) != 33'd0);
    per_inc  = period_counter + 1'b1;
  end

  // Next state for a load, a stop or a tick.
  always_comb begin
    level_next             = level;
    running_next           = running;
    half_periods_left_next = half_periods_left;
    reload_value_next      = reload_value;
    prescale_shift_next    = prescale_shift;
    prescale_counter_next  = prescale_counter;
    period_counter_next    = period_counter;
    if (ctl.load) begin
      reload_value_next      = load_reload;
      prescale_shift_next    = load_shift;
      half_periods_left_next = load_count;
      prescale_counter_next  = '0;
      period_counter_next    = '0;
      level_next             = 1'b1;
      running_next           = 1'b1;
    end else if (ctl.stop) begin
      level_next   = 1'b0;
      running_next = 1'b0;
    end else if (ctl.tick && running) begin
      if (!pre_wrap) begin
        prescale_counter_next = pre_inc[31:0];
      end else begin
        prescale_counter_next = '0;
        if (per_inc < reload_value) begin
          period_counter_next = per_inc;
        end else begin
          // Period event: parity of the count sets the level.
          period_counter_next = '0;
          if (half_periods_left != 32'd0) begin
            level_next = half_periods_left[0];
            if (half_periods_left < sqtg_pkg::ENDLESS_COUNT) begin
              half_periods_left_next = half_periods_left - 32'd1;
            end else begin
              half_periods_left_next = half_periods_left ^ 32'd1;
            end
          end else begin
            level_next   = 1'b0;
            running_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level             <= 1'b0;
      running           <= 1'b0;
      half_periods_left <= '0;
      reload_value      <= RELOAD_W'(1);
      prescale_shift    <= '0;
      prescale_counter  <= '0;
      period_counter    <= '0;
    end else begin
      level             <= level_next;
      running           <= running_next;
      half_periods_left <= half_periods_left_next;
      reload_value      <= reload_value_next;
      prescale_shift    <= prescale_shift_next;
      prescale_counter  <= prescale_counter_next;
      period_counter    <= period_counter_next;
    end
  end

  assign state_next.pin_level = level_next;
  assign state_next.active    = running_next;

endmodule

// File: rtl/square_tone_generator.sv
// Top level of the square tone generator: command sequencer and output queue.
//
// Usage: each input word carries a command. A tick advances the tone timer,
// a start loads a new tone from frequency_hz and duration_ms, a stop ends the
// tone. Every accepted word gives exactly one result word with the output
// level and the running flag after that command.
// cfg_write with cfg_data sets the timer clock rate; write it only while idle.
// Ticks, stops, ignored starts (zero frequency) and unused codes do not stall
// the input: one word can be accepted every cycle while in_stall is low, and
// its result is registered into the output queue. A start is computed by two
// 53-step passes through the shared shift-subtract divider
// (clock / (2 * frequency), then frequency * duration * 2 / 1000) and then the
// reload halvings (0 to 15 at the default limit, up to 30 at a limit of 1).
// in_stall is high while a start is being computed.
// Results go to a two-word output queue; while the receiver stalls, one more
// word is accepted, then in_stall stays high until the receiver takes a word.
// Reset (rst, synchronous) stops the tone, empties the queue and sets the
// timer clock register to 80 MHz.
module square_tone_generator #(
  parameter int unsigned RELOAD_LIMIT = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sqtg_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sqtg_pkg::out_word_t  out_data,
  input  logic                 cfg_write,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned RELOAD_W = $clog2(RELOAD_LIMIT) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_CLK,
    S_CNT_GO,
    S_DIV_CNT,
    S_NORM,
    S_LOAD
  } state_t;

  state_t                         state;
  logic [31:0]                    clock_hz;
  logic [51:0]                    product;
  logic                           dur_zero;
  logic [31:0]                    reload;
  logic [sqtg_pkg::SHIFT_W-1:0]   shift;
  logic [31:0]                    count;

  logic                           accept;
  logic                           is_start;
  logic                           push;
  logic                           pop;
  sqtg_pkg::timer_ctl_t           ctl;
  sqtg_pkg::out_word_t            state_next;
  logic                           div_go;
  logic                           div_done;
  logic [sqtg_pkg::DIVIDEND_W-1:0] div_dividend;
  logic [sqtg_pkg::DIVISOR_W-1:0]  div_divisor;
  logic [sqtg_pkg::DIVIDEND_W-1:0] div_quotient;

  logic                           head_valid;
  sqtg_pkg::out_word_t            head;
  logic                           skid_valid;
  sqtg_pkg::out_word_t            skid;

  // Handshake and operation decode.
  always_comb begin
    in_stall = (state != S_IDLE) || skid_valid;
    accept   = in_valid && !in_stall;
    is_start = accept && (in_data.command == sqtg_pkg::CMD_START)
               && (in_data.frequency_hz != 20'd0);
    ctl.tick = accept && (in_data.command == sqtg_pkg::CMD_TICK);
    ctl.stop = accept && (in_data.command == sqtg_pkg::CMD_STOP);
    ctl.load = (state == S_LOAD);
    push     = (accept && !is_start) || (state == S_LOAD);
    pop      = out_valid && !out_stall;
  end

  // Divider operand selection: clock rate first, then the scaled product.
  always_comb begin
    div_go = is_start || (state == S_CNT_GO);
    if (state == S_CNT_GO) begin
      div_dividend = {product, 1'b0};
      div_divisor  = sqtg_pkg::DIVISOR_W'(sqtg_pkg::MS_PER_S);
    end else begin
      div_dividend = sqtg_pkg::DIVIDEND_W'(clock_hz);
      div_divisor  = {in_data.frequency_hz, 1'b0};
    end
  end

  sqtg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  sqtg_timer #(
    .RELOAD_W (RELOAD_W)
  ) u_timer (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .load_reload (reload[RELOAD_W-1:0]),
    .load_shift  (shift),
    .load_count  (count),
    .state_next  (state_next)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= sqtg_pkg::CLOCK_HZ_RESET;
    end else if (cfg_write) begin
      clock_hz <= cfg_data;
    end
  end

  // Start sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (is_start) begin
            product  <= 52'(in_data.frequency_hz) * 52'(in_data.duration_ms);
            dur_zero <= (in_data.duration_ms == 32'd0);
            shift    <= '0;
            state    <= S_DIV_CLK;
          end
        end
        S_DIV_CLK: begin
          if (div_done) begin
            reload <= div_quotient[31:0];
            state  <= S_CNT_GO;
          end
        end
        S_CNT_GO: begin
          state <= S_DIV_CNT;
        end
        S_DIV_CNT: begin
          if (div_done) begin
            if (dur_zero) begin
              count <= sqtg_pkg::ENDLESS_COUNT;
            end else if (div_quotient > sqtg_pkg::DIVIDEND_W'(sqtg_pkg::COUNT_MAX)) begin
              count <= sqtg_pkg::COUNT_MAX;
            end else begin
              count <= div_quotient[31:0];
            end
            if (reload == 32'd0) begin
              reload <= 32'd1;
            end
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // Halve the reload into range, doubling the prescale each time.
          if (reload > 32'(RELOAD_LIMIT)) begin
            reload <= reload >> 1;
            shift  <= shift + 1'b1;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Two-word output queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head       <= skid;
        skid_valid <= push;
        if (push) begin
          skid <= state_next;
        end
      end else begin
        head_valid <= push;
        if (push) begin
          head <= state_next;
        end
      end
    end else if (push) begin
      if (!head_valid) begin
        head       <= state_next;
        head_valid <= 1'b1;
      end else begin
        skid       <= state_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign out_valid = head_valid;
  assign out_data  = head;

endmodule

// File: rtl/sqtg_checker.sv
// Port checker for the square tone generator and its bind.
module sqtg_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input sqtg_pkg::in_word_t   in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input sqtg_pkg::out_word_t  out_data
);

  // A start with a frequency keeps the input stalled while it is computed.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.command == sqtg_pkg::CMD_START)
    && (in_data.frequency_hz != 20'd0) |=> in_stall)
    else $error("input not stalled after a start word");

  // A stop into an empty output gives an idle, low result next cycle.
  a_stop_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.command == sqtg_pkg::CMD_STOP) && !out_valid
    |=> out_valid && !out_data.pin_level && !out_data.active)
    else $error("stop word did not give an idle result");

  // The level is never high while the tone is idle.
  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.pin_level && !out_data.active))
    else $error("output high while idle");

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word dropped or changed");

endmodule

bind square_tone_generator sqtg_checker u_sqtg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/tb_top.sv
// Testbench for the square tone generator: command stimulus with a tone predictor.
`timescale 1ns / 1ps

module tb_top;

  // The command code that the block ignores.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned RELOAD_MAX = 65536;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  sqtg_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  sqtg_pkg::out_word_t out_data;
  logic                cfg_write;
  logic [31:0]         cfg_data;

  // Predicted tone state.
  logic [31:0] timer_clock;
  logic        tone_level;
  logic        tone_running;
  logic [31:0] half_periods;
  logic [16:0] reload_count;
  logic [4:0]  prescale_bits;
  logic [31:0] prescale_count;
  logic [16:0] period_count;

  sqtg_pkg::out_word_t expected_levels[$];
  int unsigned         mismatch_count;
  bit                  steady;

  square_tone_generator #(.RELOAD_LIMIT(RELOAD_MAX)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one command word to the predicted state and returns the level and running flag.
  function automatic sqtg_pkg::out_word_t tone_after_word(sqtg_pkg::in_word_t w);
    logic [31:0]         reload;
    logic [4:0]          shift;
    logic [63:0]         count;
    sqtg_pkg::out_word_t r;
    case (w.command)
      sqtg_pkg::CMD_TICK: begin
        if (tone_running) begin
          prescale_count = prescale_count + 32'd1;
          if (prescale_count >= (32'd1 << prescale_bits)) begin
            prescale_count = '0;
            period_count = period_count + 17'd1;
            if (period_count >= reload_count) begin
              period_count = '0;
              // Period event: the level follows the parity of the count.
              if (half_periods != 32'd0) begin
                tone_level = half_periods[0];
                if (half_periods < sqtg_pkg::ENDLESS_COUNT)
                  half_periods = half_periods - 32'd1;
                else half_periods[0] = ~half_periods[0];
              end else begin
                tone_level = 1'b0;
                tone_running = 1'b0;
              end
            end
          end
        end
      end
      sqtg_pkg::CMD_START: begin
        if (w.frequency_hz != 20'd0) begin
          reload = timer_clock / {12'd0, w.frequency_hz} / 32'd2;
          if (reload == 32'd0) reload = 32'd1;
          shift = '0;
          while (reload > RELOAD_MAX) begin
            reload = reload / 32'd2;
            shift = shift + 5'd1;
          end
          reload_count = reload[16:0];
          prescale_bits = shift;
          if (w.duration_ms == 32'd0) begin
            half_periods = sqtg_pkg::ENDLESS_COUNT;
          end else begin
            count = {44'd0, w.frequency_hz} * {32'd0, w.duration_ms} * 64'd2 / 64'd1000;
            half_periods = (count > {32'd0, sqtg_pkg::COUNT_MAX}) ?
                           sqtg_pkg::COUNT_MAX : count[31:0];
          end
          prescale_count = '0;
          period_count = '0;
          tone_level = 1'b1;
          tone_running = 1'b1;
        end
      end
      sqtg_pkg::CMD_STOP: begin
        tone_level = 1'b0;
        tone_running = 1'b0;
      end
      default: begin
      end
    endcase
    r.pin_level = tone_level;
    r.active = tone_running;
    return r;
  endfunction

  function automatic sqtg_pkg::in_word_t make_word(logic [1:0] c, logic [19:0] f,
                                                   logic [31:0] d);
    sqtg_pkg::in_word_t w;
    w.command = c;
    w.frequency_hz = f;
    w.duration_ms = d;
    return w;
  endfunction

  // Any command, with a frequency from 0 to 1000000 and any duration.
  function automatic sqtg_pkg::in_word_t noise_word();
    return make_word(2'($urandom_range(3, 0)), 20'($urandom_range(1000000, 0)), $urandom);
  endfunction

  // A tick whose unused fields carry random bits.
  function automatic sqtg_pkg::in_word_t tick_word();
    return make_word(sqtg_pkg::CMD_TICK, 20'($urandom_range(1000000, 0)), $urandom);
  endfunction

  // Sends one word, with a random idle gap ahead of it unless the sender is steady.
  task automatic send_word(input sqtg_pkg::in_word_t w);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99, 0) < 11) gap = $urandom_range(3, 1);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_levels.push_back(tone_after_word(w));
  endtask

  // Waits for every expected word, then writes the timer clock rate.
  task automatic write_clock_rate(input logic [31:0] hz);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= hz;
    @(posedge clk);
    timer_clock = hz;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Commands with no tone running, ignored starts and restarts at the reset clock rate.
  task automatic test_start_cases();
    send_word(make_word(sqtg_pkg::CMD_TICK, 20'd0, 32'd0));
    send_word(make_word(sqtg_pkg::CMD_STOP, 20'd0, 32'd0));
    send_word(make_word(CMD_SPARE, 20'd1000000, 32'hffff_ffff));
    send_word(make_word(sqtg_pkg::CMD_START, 20'd0, 32'hffff_ffff));
    send_word(make_word(sqtg_pkg::CMD_START, 20'd1, 32'd1));
    send_word(make_word(sqtg_pkg::CMD_TICK, 20'd1000000, 32'hffff_ffff));
    send_word(make_word(sqtg_pkg::CMD_STOP, 20'd0, 32'd0));
    send_word(make_word(sqtg_pkg::CMD_START, 20'd1000000, 32'hffff_ffff));
    send_word(make_word(sqtg_pkg::CMD_START, 20'd1000000, 32'd0));
    send_word(make_word(sqtg_pkg::CMD_TICK, 20'd0, 32'd0));
    send_word(make_word(CMD_SPARE, 20'd0, 32'd0));
    send_word(make_word(sqtg_pkg::CMD_START, 20'd524288, 32'd1));
    send_word(make_word(sqtg_pkg::CMD_START, 20'd1000, 32'h8000_0000));
    send_word(make_word(sqtg_pkg::CMD_STOP, 20'd0, 32'd0));
    send_word(make_word(sqtg_pkg::CMD_TICK, 20'd0, 32'd0));
  endtask

  // With a zero clock rate every tick is a period event.
  task automatic test_zero_clock();
    write_clock_rate(32'd0);
    // A tone too short for even one half period.
    send_word(make_word(sqtg_pkg::CMD_START, 20'd1, 32'd1));
    send_word(tick_word());
    send_word(tick_word());
    // A counted tone runs down to zero and stops.
    send_word(make_word(sqtg_pkg::CMD_START, 20'd7, 32'd500));
    repeat (10) send_word(tick_word());
    // An endless tone keeps toggling.
    send_word(make_word(sqtg_pkg::CMD_START, 20'd3, 32'd0));
    repeat (6) send_word(tick_word());
    send_word(make_word(sqtg_pkg::CMD_STOP, 20'd0, 32'd0));
  endtask

  // Tones with random content at one clock rate, with some noise in between.
  task automatic test_random_tones(input logic [31:0] hz, input int unsigned n_items);
    int unsigned sent;
    int unsigned ticks;
    logic [31:0] dur;
    write_clock_rate(hz);
    sent = 0;
    while (sent < n_items) begin
      steady = (sent >= n_items / 3) && (sent < n_items / 2);
      if ($urandom_range(99, 0) < 10) begin
        send_word(noise_word());
        sent = sent + 1;
      end else begin
        case ($urandom_range(9, 0))
          0: dur = 32'd0;
          1: dur = $urandom;
          default: dur = $urandom_range(5000, 1);
        endcase
        send_word(make_word(sqtg_pkg::CMD_START, 20'($urandom_range(8, 1)), dur));
        ticks = $urandom_range(60, 4);
        repeat (ticks) send_word(tick_word());
        if ($urandom_range(3, 0) == 0)
          send_word(make_word(sqtg_pkg::CMD_STOP, 20'd0, 32'd0));
        sent = sent + ticks + 2;
      end
    end
    steady = 0;
  endtask

  // A reload just over the limit forces a prescaler divide by two; the first
  // half period is far longer than the ticks sent, so the level holds high.
  task automatic test_prescaled_period();
    write_clock_rate(32'd131074);
    send_word(make_word(sqtg_pkg::CMD_START, 20'd1, 32'd1500));
    repeat (20) send_word(tick_word());
    send_word(make_word(sqtg_pkg::CMD_STOP, 20'd0, 32'd0));
  endtask

  // The largest clock rate gives the deepest halving.
  task automatic test_max_clock();
    write_clock_rate(32'hffff_ffff);
    send_word(make_word(sqtg_pkg::CMD_START, 20'd1, $urandom));
    repeat (5) send_word(tick_word());
    send_word(make_word(sqtg_pkg::CMD_START, 20'd1000000, 32'd0));
    repeat (5) send_word(tick_word());
    send_word(make_word(sqtg_pkg::CMD_START, 20'd3, 32'd7));
    send_word(make_word(sqtg_pkg::CMD_STOP, 20'd0, 32'd0));
  endtask

  // Receiver stall, quiet while the sender is steady.
  always @(negedge clk) begin
    if (rst || steady) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99, 0) < 11);
  end

  // Each result word is checked against the oldest expectation.
  always @(posedge clk) begin : check_result
    sqtg_pkg::out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("unexpected result word: pin_level %b active %b",
                   out_data.pin_level, out_data.active);
      end else begin
        want = expected_levels.pop_front();
        if (out_data.pin_level !== want.pin_level || out_data.active !== want.active) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("result mismatch: pin_level exp %b got %b, active exp %b got %b",
                     want.pin_level, out_data.pin_level, want.active, out_data.active);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    steady = 0;
    mismatch_count = 0;
    timer_clock = sqtg_pkg::CLOCK_HZ_RESET;
    tone_level = 1'b0;
    tone_running = 1'b0;
    half_periods = '0;
    reload_count = 17'd1;
    prescale_bits = '0;
    prescale_count = '0;
    period_count = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_start_cases();
    test_zero_clock();
    test_random_tones(32'd1, 50);
    test_random_tones(32'd3, 70);
    test_random_tones(32'd12, 90);
    test_random_tones(32'd40, 90);
    test_random_tones(32'd0, 50);
    test_prescaled_period();
    test_max_clock();
    test_random_tones(sqtg_pkg::CLOCK_HZ_RESET, 30);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
